[hdl/okl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// okl_pkg: shared types and codes for the ordered keyed list table
// record, request, response and scan token layouts plus operation and status codes
// ----------------------------------------------------------------------------
package okl_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  localparam logic signed [31:0] NO_KEY = -32'sd1;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] quantity;
    logic signed [31:0] price;
  } rec_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] item_key;
    logic signed [31:0] item_quantity;
    logic signed [31:0] item_price;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] removed_key;
    logic signed [31:0] removed_quantity;
    logic signed [31:0] removed_price;
    logic [6:0]         entry_count;
    logic               is_empty;
  } rsp_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic tok;
    logic hit;
    rec_t rem;
  } token_t;

endpackage
`default_nettype wire

[hdl/ordered_keyed_list_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_keyed_list_table: insertion-ordered record table
// keyed records kept in a chain of cells; insert at tail, search, and
// delete of the oldest match with the rest closing the gap in order
// ----------------------------------------------------------------------------
//
//   channel   signals                          beat
//   request   req_valid / req_stall / req      operation, key, quantity, price
//   response  rsp_valid / rsp_stall / rsp      status, removed record, count
//
// insert or unused code: result staged at the request beat, loaded into the
//   response register from the staging register once that register is free
// search/delete: a token walks the chain one cell per cycle through every
//   cell, then the result is staged and moved into the response register;
//   the chain length, not the record count, sets how far the token walks
// one operation in flight; req_stall is high from acceptance until the
//   result has moved into the response register
// a finished result waits in a staging register while rsp_stall holds the
//   response register
// reset clears control state and the record count; stored records are not
//   cleared, slots at or above the count are never read
// ----------------------------------------------------------------------------
module ordered_keyed_list_table #(
  parameter int ENTRIES = 64
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  output logic            req_stall,
  input  wire okl_pkg::req_t req,
  output logic            rsp_valid,
  input  wire             rsp_stall,
  output okl_pkg::rsp_t   rsp
);

  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               op_del;
  logic signed [31:0] key_reg;
  okl_pkg::rsp_t      stage;
  okl_pkg::rsp_t      stage_next;

  logic               accept;
  logic               is_scan_op;
  logic               ins_en;
  logic               push;
  okl_pkg::rec_t      ins_rec;
  okl_pkg::token_t    start_tok;
  okl_pkg::token_t    tail;

  okl_pkg::token_t    tk_out [ENTRIES];
  okl_pkg::rec_t      recs   [ENTRIES];
  logic [ENTRIES-1:0] tok_bits;

  assign req_stall  = state != S_IDLE;
  assign accept     = req_valid && !req_stall;
  assign is_scan_op = req.operation inside {okl_pkg::OP_SEARCH, okl_pkg::OP_DELETE};
  assign ins_en     = accept && (req.operation == okl_pkg::OP_INSERT)
                      && (count < CW'(ENTRIES));
  assign push       = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    ins_rec.key      = req.item_key;
    ins_rec.quantity = req.item_quantity;
    ins_rec.price    = req.item_price;
    start_tok.tok    = accept && is_scan_op;
    start_tok.hit    = 1'b0;
    start_tok.rem    = '0;
  end

  // the chain: the token moves one cell per cycle, records shift toward the head on delete
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    okl_pkg::token_t t_in;
    okl_pkg::rec_t   n_rec;
    if (i == 0) begin : g_head
      assign t_in = start_tok;
    end else begin : g_body
      assign t_in = tk_out[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign n_rec = recs[i];
    end else begin : g_next
      assign n_rec = recs[i+1];
    end
    okl_cell #(
      .ENTRIES (ENTRIES),
      .INDEX   (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .key     (key_reg),
      .del     (op_del),
      .ins_en  (ins_en),
      .ins_rec (ins_rec),
      .tok_in  (t_in),
      .nbr_rec (n_rec),
      .rec     (recs[i]),
      .tok_out (tk_out[i])
    );
    assign tok_bits[i] = tk_out[i].tok;
  end

  assign tail = tk_out[ENTRIES-1];

  // count and staged result, formed at acceptance or when the token leaves
  always_comb begin
    count_next                  = count;
    stage_next                  = stage;
    if (accept && !is_scan_op) begin
      if (ins_en) begin
        count_next = count + CW'(1);
      end
      stage_next.status           = (req.operation == okl_pkg::OP_INSERT && !ins_en)
                                    ? okl_pkg::ST_FULL : okl_pkg::ST_OK;
      stage_next.found            = 1'b0;
      stage_next.removed_key      = okl_pkg::NO_KEY;
      stage_next.removed_quantity = '0;
      stage_next.removed_price    = '0;
      stage_next.entry_count      = 7'(count_next);
      stage_next.is_empty         = count_next == '0;
    end else if (state == S_SCAN && tail.tok) begin
      if (tail.hit && op_del) begin
        count_next = count - CW'(1);
      end
      stage_next.status           = tail.hit ? okl_pkg::ST_OK : okl_pkg::ST_MISSING;
      stage_next.found            = tail.hit;
      stage_next.removed_key      = (tail.hit && op_del) ? tail.rem.key : okl_pkg::NO_KEY;
      stage_next.removed_quantity = (tail.hit && op_del) ? tail.rem.quantity : '0;
      stage_next.removed_price    = (tail.hit && op_del) ? tail.rem.price : '0;
      stage_next.entry_count      = 7'(count_next);
      stage_next.is_empty         = count_next == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      count <= count_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= is_scan_op ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (tail.tok) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (push) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    stage <= stage_next;
    if (accept) begin
      op_del  <= req.operation == okl_pkg::OP_DELETE;
      key_reg <= req.item_key;
    end
    if (push) begin
      rsp <= stage;
    end
  end

  // at most one token anywhere in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_bits))
    else $error("more than one scan token in the chain");

  // a token only exists during a scan
  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    (tok_bits != '0) |-> (state == S_SCAN))
    else $error("scan token outside of scan state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("record count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("request beat accepted without leaving idle");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && tail.tok) |=> (state == S_DONE))
    else $error("scan token left the chain without a staged result");

endmodule
`default_nettype wire

[hdl/okl_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// okl_cell: one record slot of the table chain
// holds one record, compares it as the scan token passes, shifts on delete
// ----------------------------------------------------------------------------
module okl_cell #(
  parameter int ENTRIES = 64,
  parameter int INDEX   = 0
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire [$clog2(ENTRIES+1)-1:0] count,
  input  wire signed [31:0]           key,
  input  wire                         del,
  input  wire                         ins_en,
  input  wire okl_pkg::rec_t          ins_rec,
  input  wire okl_pkg::token_t        tok_in,
  input  wire okl_pkg::rec_t          nbr_rec,
  output okl_pkg::rec_t               rec,
  output okl_pkg::token_t             tok_out
);

  localparam int CW = $clog2(ENTRIES + 1);

  okl_pkg::token_t tok;
  logic            live;
  logic            match;

  assign live  = count > CW'(INDEX);
  assign match = tok.tok && live && !tok.hit && (rec.key == key);

  always_comb begin
    tok_out.tok = tok.tok;
    tok_out.hit = tok.hit | match;
    tok_out.rem = match ? rec : tok.rem;
  end

  // token flag is cleared by reset, the carried hit and record need no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.tok <= 1'b0;
    end else begin
      tok.tok <= tok_in.tok;
    end
    tok.hit <= tok_in.hit;
    tok.rem <= tok_in.rem;
  end

  // append on insert, take the neighbor's record at the match and in every cell after it
  always_ff @(posedge clk) begin
    if (ins_en && (count == CW'(INDEX))) begin
      rec <= ins_rec;
    end else if (tok.tok && del && (tok.hit || match)) begin
      rec <= nbr_rec;
    end
  end

endmodule
`default_nettype wire

[tb/sv/okl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_checker: response checker for the ordered keyed list table
// watches both channels, keeps a shadow copy of the record table, works out
// the response for every accepted request and compares it in order
// ----------------------------------------------------------------------------
module okl_checker #(
  parameter int DEPTH = 64
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  input  wire            req_stall,
  input  okl_pkg::req_t  req,
  input  wire            rsp_valid,
  input  wire            rsp_stall,
  input  okl_pkg::rsp_t  rsp,
  output int             fail_count,
  output int             pending,
  output int             results_seen,
  output int             full_drops,
  output int             delete_hits,
  output int             peak_fill
);

  okl_pkg::rec_t shadow [DEPTH];
  int            held;
  int            fails, checked, drops, hits, peak;
  okl_pkg::rsp_t expected_rsp [$];

  // one table operation on the shadow copy, returns the response it gives
  function automatic okl_pkg::rsp_t table_op(input okl_pkg::req_t r);
    okl_pkg::rsp_t o;
    int            pos;
    o = '0;
    o.status = okl_pkg::ST_OK;
    o.removed_key = okl_pkg::NO_KEY;
    pos = held;
    if (r.operation == okl_pkg::OP_SEARCH || r.operation == okl_pkg::OP_DELETE) begin
      for (int i = 0; i < held; i++) begin
        if (shadow[i].key == r.item_key) begin
          pos = i;
          break;
        end
      end
    end
    case (r.operation)
      okl_pkg::OP_INSERT: begin
        if (held >= DEPTH) begin
          o.status = okl_pkg::ST_FULL;
          drops++;
        end else begin
          shadow[held] = '{key: r.item_key, quantity: r.item_quantity, price: r.item_price};
          held++;
        end
      end
      okl_pkg::OP_SEARCH: begin
        if (pos < held) o.found = 1'b1;
        else o.status = okl_pkg::ST_MISSING;
      end
      okl_pkg::OP_DELETE: begin
        if (pos < held) begin
          o.found = 1'b1;
          o.removed_key = shadow[pos].key;
          o.removed_quantity = shadow[pos].quantity;
          o.removed_price = shadow[pos].price;
          for (int i = pos; i + 1 < held; i++) shadow[i] = shadow[i + 1];
          held--;
          hits++;
        end else begin
          o.status = okl_pkg::ST_MISSING;
        end
      end
      default: ;
    endcase
    o.entry_count = 7'(held);
    o.is_empty = (held == 0);
    if (held > peak) peak = held;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    okl_pkg::rsp_t want;
    if (rst) begin
      held = 0;
      expected_rsp.delete();
    end else begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        checked++;
        if (expected_rsp.size() == 0) begin
          $error("response beat with no request outstanding");
          fails++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("found", 32'(want.found), 32'(rsp.found));
          check_field("removed_key", want.removed_key, rsp.removed_key);
          check_field("removed_quantity", want.removed_quantity, rsp.removed_quantity);
          check_field("removed_price", want.removed_price, rsp.removed_price);
          check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
          check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
        end
      end
      if (req_valid === 1'b1 && req_stall === 1'b0) expected_rsp.push_back(table_op(req));
    end
    fail_count <= fails;
    pending <= expected_rsp.size();
    results_seen <= checked;
    full_drops <= drops;
    delete_hits <= hits;
    peak_fill <= peak;
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: ordered keyed list table
// directed requests for the corner cases (empty table, duplicate keys, the
// all-ones key, extremes of every field, unused operation code), then random
// phases that fill the table past full, drain it and mix operations, with
// random idle bursts on both channels; okl_checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH      = 64;
  localparam int N_ITEMS    = 1100;
  localparam int QUIET_TAIL = 120;

  // operation code the block does not define, must leave the table alone
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  okl_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  okl_pkg::rsp_t rsp;

  int fail_count, pending, results_seen, full_drops, delete_hits, peak_fill;

  // idle controls: per phase on/off, and the quiet tail with no idling at all
  bit quiet;
  bit send_idle;
  bit recv_idle;

  int                 op_sent [4];
  int                 sent;
  logic signed [31:0] key_pool [8];
  // keys inserted lately, so drain phases mostly delete keys that are held
  logic signed [31:0] live_keys [$];

  ordered_keyed_list_table #(.ENTRIES(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  okl_checker #(.DEPTH(DEPTH)) u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .full_drops   (full_drops),
    .delete_hits  (delete_hits),
    .peak_fill    (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit: ends the run as a failure if it has not finished by this time
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // response side: runs of ready cycles broken, while idling is on, by stall bursts of random length
  initial begin
    int n;
    rsp_stall = 1'b0;
    forever begin
      n = $urandom_range(1, 24);
      repeat (n) begin
        @(negedge clk);
        rsp_stall <= 1'b0;
      end
      if (!quiet && recv_idle && $urandom_range(0, 2) != 0) begin
        n = $urandom_range(1, 18);
        repeat (n) begin
          @(negedge clk);
          rsp_stall <= 1'b1;
        end
      end
    end
  end

  function automatic okl_pkg::req_t make_req(input logic [1:0] op,
                                             input logic signed [31:0] k,
                                             input logic signed [31:0] qty,
                                             input logic signed [31:0] price);
    okl_pkg::req_t r;
    r.operation = op;
    r.item_key = k;
    r.item_quantity = qty;
    r.item_price = price;
    return r;
  endfunction

  // mostly full-range random words, with the extremes mixed in
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // small keys collide often, wide random ones toggle every key bit
  task automatic refresh_pool();
    foreach (key_pool[i]) begin
      key_pool[i] = ($urandom_range(0, 2) == 0) ? rand_word() : $urandom_range(0, 20);
    end
  endtask

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 6) == 0) return rand_word();
    return key_pool[$urandom_range(0, 7)];
  endfunction

  // one request beat, driven at the falling edge and held until accepted
  task automatic send(input okl_pkg::req_t beat);
    @(negedge clk);
    req_valid <= 1'b1;
    req <= beat;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    op_sent[beat.operation]++;
    sent++;
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // hold the request side until every outstanding response is back
  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    phase_t             ph;
    int                 len;
    int                 roll;
    int                 idx;
    logic [1:0]         op;
    logic signed [31:0] k;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    quiet = 1'b0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    sent = 0;
    foreach (op_sent[i]) op_sent[i] = 0;
    refresh_pool();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table: lookups miss, unused code does nothing
    send(make_req(okl_pkg::OP_SEARCH, 32'sd5, 32'sd0, 32'sd0));
    send(make_req(okl_pkg::OP_DELETE, 32'sd5, 32'sd0, 32'sd0));
    send(make_req(OP_SPARE, 32'sd5, 32'sd1, 32'sd1));
    // extremes of every field, and a key equal to the no-match marker
    send(make_req(okl_pkg::OP_INSERT, WORD_MIN, WORD_MAX, WORD_MIN));
    send(make_req(okl_pkg::OP_INSERT, WORD_MAX, WORD_MIN, WORD_MAX));
    send(make_req(okl_pkg::OP_INSERT, -32'sd1, 32'sd0, 32'sd0));
    send(make_req(okl_pkg::OP_INSERT, 32'sd0, -32'sd1, -32'sd1));
    // duplicate key: search and delete act on the oldest one
    send(make_req(okl_pkg::OP_INSERT, 32'sd7, 32'sd1, 32'sd2));
    send(make_req(okl_pkg::OP_INSERT, 32'sd7, 32'sd3, 32'sd4));
    send(make_req(okl_pkg::OP_SEARCH, 32'sd7, 32'sd9, 32'sd9));
    send(make_req(okl_pkg::OP_SEARCH, 32'sd12345, 32'sd0, 32'sd0));
    send(make_req(okl_pkg::OP_SEARCH, WORD_MIN, 32'sd0, 32'sd0));
    send(make_req(okl_pkg::OP_DELETE, 32'sd7, 32'sd0, 32'sd0));
    send(make_req(okl_pkg::OP_SEARCH, 32'sd7, 32'sd0, 32'sd0));
    // all-ones key held: a hit returns the same key value a miss reports
    send(make_req(okl_pkg::OP_DELETE, -32'sd1, 32'sd0, 32'sd0));
    send(make_req(okl_pkg::OP_DELETE, -32'sd1, 32'sd0, 32'sd0));
    send(make_req(OP_SPARE, WORD_MAX, WORD_MAX, WORD_MAX));
    // head, tail, the new tail, then the last record so the table runs empty
    send(make_req(okl_pkg::OP_DELETE, WORD_MIN, 32'sd0, 32'sd0));
    send(make_req(okl_pkg::OP_DELETE, 32'sd7, 32'sd0, 32'sd0));
    send(make_req(okl_pkg::OP_DELETE, 32'sd0, 32'sd0, 32'sd0));
    send(make_req(okl_pkg::OP_DELETE, WORD_MAX, 32'sd0, 32'sd0));
    send(make_req(okl_pkg::OP_SEARCH, WORD_MAX, 32'sd0, 32'sd0));

    // sender hold-off until all responses are in
    wait_drained();

    // random phases: fill past full, drain back down, or a plain mix
    while (sent < N_ITEMS) begin
      ph = phase_t'($urandom_range(0, 2));
      len = $urandom_range(30, 110);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      refresh_pool();
      if ($urandom_range(0, 2) == 0) wait_drained();
      repeat (len) begin
        if (sent >= N_ITEMS) break;
        quiet = (sent >= N_ITEMS - QUIET_TAIL);
        roll = $urandom_range(0, 99);
        case (ph)
          PH_FILL: op = (roll < 78) ? okl_pkg::OP_INSERT :
                        (roll < 88) ? okl_pkg::OP_SEARCH :
                        (roll < 97) ? okl_pkg::OP_DELETE : OP_SPARE;
          PH_DRAIN: op = (roll < 12) ? okl_pkg::OP_INSERT :
                         (roll < 27) ? okl_pkg::OP_SEARCH :
                         (roll < 96) ? okl_pkg::OP_DELETE : OP_SPARE;
          default: op = (roll < 40) ? okl_pkg::OP_INSERT :
                        (roll < 65) ? okl_pkg::OP_SEARCH :
                        (roll < 95) ? okl_pkg::OP_DELETE : OP_SPARE;
        endcase
        k = pick_key();
        if (op == okl_pkg::OP_INSERT) begin
          live_keys.push_back(k);
          if (live_keys.size() > 128) void'(live_keys.pop_front());
        end else if (op == okl_pkg::OP_DELETE && ph == PH_DRAIN && live_keys.size() > 0 &&
                     $urandom_range(0, 9) < 7) begin
          idx = $urandom_range(0, live_keys.size() - 1);
          k = live_keys[idx];
          live_keys.delete(idx);
        end
        if (!quiet && send_idle && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 18));
        send(make_req(op, k, rand_word(), rand_word()));
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    // room for any stray response after the last expected one
    repeat (DEPTH + 8) @(posedge clk);

    $display("run: %0d requests (%0d insert, %0d search, %0d delete, %0d unused code), %0d checked",
             sent, op_sent[okl_pkg::OP_INSERT], op_sent[okl_pkg::OP_SEARCH],
             op_sent[okl_pkg::OP_DELETE], op_sent[OP_SPARE], results_seen);
    $display("table peaked at %0d of %0d records, %0d inserts dropped when full, %0d deletes hit",
             peak_fill, DEPTH, full_drops, delete_hits);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
